// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on every clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check an implication that lands on the following clock edge.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/ssfmt_pkg.sv -----
`default_nettype none

package ssfmt_pkg;

    // Command codes on the func field.
    typedef enum logic [1:0] {
        FUNC_TIME  = 2'd0,
        FUNC_TEMP  = 2'd1,
        FUNC_GLYPH = 2'd2,
        FUNC_SCAN  = 2'd3
    } t_func;

    typedef logic [3:0] t_glyph;

    // Special glyph indexes.
    localparam t_glyph GL_BLANK  = 4'd10;
    localparam t_glyph GL_DEGREE = 4'd11;
    localparam t_glyph GL_C      = 4'd12;
    localparam t_glyph GL_N      = 4'd13;
    localparam t_glyph GL_O      = 4'd14;

    localparam logic [7:0] TEMP_LIMIT = 8'd99;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_time;
        logic ld_temp;
        logic ld_glyph;
        logic scan_clr;
        logic scan_adv;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

    typedef struct packed {
        t_glyph tens;
        t_glyph units;
    } t_split;

    // Split a value below 128 into decimal tens and units (reciprocal multiply).
    function automatic t_split f_split10(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rest;
        t_split      res;
        prod      = 15'(v) * 15'd205;
        tens      = prod[14:11];
        rest      = v - (7'(tens) * 7'd10);
        res.tens  = tens;
        res.units = rest[3:0];
        return res;
    endfunction

    // Segment code for a glyph index; index 15 shows blank.
    function automatic logic [7:0] f_seg(input t_glyph g);
        logic [7:0] s;
        case (g)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            4'd11:   s = 8'h63;
            4'd12:   s = 8'h39;
            4'd13:   s = 8'h54;
            4'd14:   s = 8'h5C;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssfmt_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module ssfmt_datapath #(
    parameter int NUM_DIGITS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ssfmt_pkg::t_dp_cmd i_cmd,
    output ssfmt_pkg::t_dp_stat     o_stat,
    input  wire logic [4:0]         i_hour,
    input  wire logic [5:0]         i_minute,
    input  wire logic [5:0]         i_second,
    input  wire logic [7:0]         i_temperature,
    input  wire logic               i_outdoor,
    input  wire logic [1:0]         i_position,
    input  wire logic [3:0]         i_glyph,
    output logic [7:0]              o_segment_bits,
    output logic [3:0]              o_digit_select,
    output logic                    o_colon_on,
    output logic                    o_last
);
    import ssfmt_pkg::*;

    localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_DIGITS - 1);

    t_glyph           r_glyphs [NUM_DIGITS];
    logic             r_dots   [NUM_DIGITS];
    logic             r_colon;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    t_split           hour_sp;
    t_split           min_sp;
    t_split           temp_sp;
    logic             temp_neg;
    logic [7:0]       temp_mag;
    logic             temp_over;
    t_glyph           fix_g [4];
    logic             fix_d [4];

    // Split time and temperature into digits.
    assign hour_sp   = f_split10({2'b00, i_hour});
    assign min_sp    = f_split10({1'b0, i_minute});
    assign temp_neg  = i_temperature[7];
    assign temp_mag  = temp_neg ? (8'd0 - i_temperature) : i_temperature;
    assign temp_over = temp_mag > TEMP_LIMIT;
    assign temp_sp   = f_split10(temp_mag[6:0]);

    // Pick the glyph and dot for the four fixed positions.
    always_comb begin
        if (i_cmd.ld_time) begin
            fix_g[0] = hour_sp.tens;
            fix_g[1] = hour_sp.units;
            fix_g[2] = min_sp.tens;
            fix_g[3] = min_sp.units;
        end else if (temp_over) begin
            fix_g[0] = GL_N;
            fix_g[1] = GL_O;
            fix_g[2] = GL_BLANK;
            fix_g[3] = GL_BLANK;
        end else begin
            fix_g[0] = temp_sp.tens;
            fix_g[1] = temp_sp.units;
            fix_g[2] = GL_DEGREE;
            fix_g[3] = GL_C;
        end
        fix_d[0] = i_cmd.ld_temp & temp_neg;
        fix_d[1] = i_cmd.ld_temp & temp_neg;
        fix_d[2] = 1'b0;
        fix_d[3] = 1'b0;
    end

    // Update digit store; positions past the fourth only see dot clears.
    for (genvar gd = 0; gd < NUM_DIGITS; gd++) begin : g_digit
        if (gd < 4) begin : g_lo
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_glyphs[gd] <= '0;
                    r_dots[gd]   <= 1'b0;
                end else if (i_cmd.ld_time || i_cmd.ld_temp) begin
                    r_glyphs[gd] <= fix_g[gd];
                    r_dots[gd]   <= fix_d[gd];
                end else if (i_cmd.ld_glyph && (i_position == 2'(gd))) begin
                    r_glyphs[gd] <= i_glyph;
                end
            end
        end else begin : g_hi
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_glyphs[gd] <= '0;
                    r_dots[gd]   <= 1'b0;
                end else if (i_cmd.ld_time || i_cmd.ld_temp) begin
                    r_dots[gd]   <= 1'b0;
                end
            end
        end
    end

    // Hold the colon flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colon <= 1'b0;
        end else if (i_cmd.ld_time) begin
            r_colon <= i_second[0];
        end else if (i_cmd.ld_temp) begin
            r_colon <= i_outdoor;
        end
    end

    // Advance the scan digit counter.
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.scan_clr) begin
            n_cnt = '0;
        end else if (i_cmd.scan_adv) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Drive the current digit's beat.
    assign o_stat.scan_last = (r_cnt == LAST_IDX);
    assign o_segment_bits   = f_seg(r_glyphs[r_cnt]) | {r_dots[r_cnt], 7'b0};
    assign o_digit_select   = 4'b0001 << r_cnt;
    assign o_colon_on       = r_colon;
    assign o_last           = i_cmd.emit & o_stat.scan_last;

    `ASSERT_NEXT(a_cnt_step, i_cmd.scan_adv && !o_stat.scan_last && !i_cmd.scan_clr, r_cnt == CNT_W'($past(r_cnt) + 1'b1))
    `ASSERT_IMPL(a_sel_onehot, i_cmd.emit, $onehot0(o_digit_select))
    `ASSERT_NEXT(a_clr_first, i_cmd.scan_clr, r_cnt == '0)

endmodule

`default_nettype wire

// ----- rtl/core/ssfmt_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module ssfmt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [1:0]          i_func,
    input  wire ssfmt_pkg::t_dp_stat i_stat,
    output ssfmt_pkg::t_dp_cmd       o_cmd,
    output logic                     o_busy,
    output logic                     o_valid
);
    import ssfmt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;
    t_func  func;

    assign func = t_func'(i_func);
    assign take = (r_state == S_IDLE) && i_start;

    // Step through idle and the digit scan.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && (func == FUNC_SCAN)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Issue datapath commands.
    assign o_cmd.ld_time  = take && (func == FUNC_TIME);
    assign o_cmd.ld_temp  = take && (func == FUNC_TEMP);
    assign o_cmd.ld_glyph = take && (func == FUNC_GLYPH);
    assign o_cmd.scan_clr = take && (func == FUNC_SCAN);
    assign o_cmd.scan_adv = (r_state == S_SCAN);
    assign o_cmd.emit     = (r_state == S_SCAN);
    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = o_cmd.emit;

    `ASSERT_NEXT(a_scan_ends, (r_state == S_SCAN) && i_stat.scan_last, r_state == S_IDLE)
    `ASSERT_NEXT(a_scan_enters, o_cmd.scan_clr, o_valid)
    `ASSERT_IMPL(a_no_load_busy, o_busy, !(o_cmd.ld_time || o_cmd.ld_temp || o_cmd.ld_glyph))

endmodule

`default_nettype wire

// ----- rtl/core/seven_segment_four_digit_formatter_core.sv -----
`default_nettype none

// Four-digit seven-segment formatter. A command is taken when i_start is high
// and o_busy is low. Set-time, set-temperature and set-glyph commands update
// the digit store in the cycle they are taken and produce no output, so the
// next command may follow in the very next cycle. A refresh makes the block
// busy while the scan counter walks the digit store: each cycle carries one
// beat on the o_ ports, marked by o_valid, digit 0 first, with o_last on the
// final digit. The receiver cannot stall: every beat is present for exactly
// one cycle and must be taken.
module seven_segment_four_digit_formatter_core #(
    parameter int NUM_DIGITS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [1:0] i_func,
    input  wire logic [4:0] i_hour,
    input  wire logic [5:0] i_minute,
    input  wire logic [5:0] i_second,
    input  wire logic [7:0] i_temperature,
    input  wire logic       i_outdoor,
    input  wire logic [1:0] i_position,
    input  wire logic [3:0] i_glyph,
    output logic            o_valid,
    output logic [7:0]      o_segment_bits,
    output logic [3:0]      o_digit_select,
    output logic            o_colon_on,
    output logic            o_last
);
    import ssfmt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence commands and scans.
    ssfmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    // Hold the digit store and format each digit.
    ssfmt_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_second       (i_second),
        .i_temperature  (i_temperature),
        .i_outdoor      (i_outdoor),
        .i_position     (i_position),
        .i_glyph        (i_glyph),
        .o_segment_bits (o_segment_bits),
        .o_digit_select (o_digit_select),
        .o_colon_on     (o_colon_on),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ----- tb/ssfmt_beat_checker.sv -----
`timescale 1ns / 1ps

module ssfmt_beat_checker #(
    parameter int NUM_DIGITS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  wire logic [1:0] i_func,
    input  wire logic [4:0] i_hour,
    input  wire logic [5:0] i_minute,
    input  wire logic [5:0] i_second,
    input  wire logic [7:0] i_temperature,
    input  wire logic       i_outdoor,
    input  wire logic [1:0] i_position,
    input  wire logic [3:0] i_glyph,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_segment_bits,
    input  wire logic [3:0] i_digit_select,
    input  wire logic       i_colon_on,
    input  wire logic       i_last,
    output int              o_mismatch_count,
    output int              o_beats_pending
);
    import ssfmt_pkg::*;

    typedef struct packed {
        logic [7:0] segment_bits;
        logic [3:0] digit_select;
        logic       colon_on;
        logic       last;
    } t_digit_beat;

    // Segment codes, glyph 0 in the low byte; glyphs 10 and 15 stay dark.
    localparam logic [127:0] SEGMENT_CODES = {
        8'h00, 8'h5C, 8'h54, 8'h39, 8'h63, 8'h00, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    t_glyph      shown_glyphs [NUM_DIGITS];
    logic        lit_dots     [NUM_DIGITS];
    logic        colon_lit;
    t_digit_beat digit_beats_due [$];
    int          mismatches;

    // Write one digit position; positions past the display are dropped.
    task automatic set_glyph(input int idx, input t_glyph g);
        if (idx < NUM_DIGITS) begin
            shown_glyphs[idx] = g;
        end
    endtask

    task automatic set_dot(input int idx, input logic dot);
        if (idx < NUM_DIGITS) begin
            lit_dots[idx] = dot;
        end
    endtask

    // Update the display image for one command and queue the beats it causes.
    task automatic apply_command(input logic [1:0] func, input logic [4:0] hour,
                                 input logic [5:0] minute, input logic [5:0] second,
                                 input logic [7:0] temperature, input logic outdoor,
                                 input logic [1:0] position, input t_glyph glyph);
        logic        negative;
        logic [8:0]  magnitude;
        t_digit_beat beat;
        case (func)
            FUNC_TIME: begin
                for (int i = 0; i < NUM_DIGITS; i++) lit_dots[i] = 1'b0;
                set_glyph(0, 4'(hour / 10));
                set_glyph(1, 4'(hour % 10));
                set_glyph(2, 4'(minute / 10));
                set_glyph(3, 4'(minute % 10));
                colon_lit = second[0];
            end
            FUNC_TEMP: begin
                negative  = temperature[7];
                magnitude = negative ? (9'd256 - {1'b0, temperature})
                                     : {1'b0, temperature};
                for (int i = 0; i < NUM_DIGITS; i++) lit_dots[i] = 1'b0;
                if (magnitude > 9'd99) begin
                    set_glyph(0, GL_N);
                    set_glyph(1, GL_O);
                    set_glyph(2, GL_BLANK);
                    set_glyph(3, GL_BLANK);
                end else begin
                    set_glyph(0, 4'(magnitude / 10));
                    set_glyph(1, 4'(magnitude % 10));
                    set_glyph(2, GL_DEGREE);
                    set_glyph(3, GL_C);
                end
                set_dot(0, negative);
                set_dot(1, negative);
                set_dot(2, 1'b0);
                set_dot(3, 1'b0);
                colon_lit = outdoor;
            end
            FUNC_GLYPH: begin
                set_glyph(int'(position), glyph);
            end
            default: begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    beat.segment_bits = SEGMENT_CODES[{shown_glyphs[i], 3'b000} +: 8];
                    beat.segment_bits[7] = beat.segment_bits[7] | lit_dots[i];
                    beat.digit_select = 4'(1 << i);
                    beat.colon_on     = colon_lit;
                    beat.last         = (i == NUM_DIGITS - 1);
                    digit_beats_due.push_back(beat);
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input t_digit_beat want,
                                 input t_digit_beat got);
        if (mismatches < 10) begin
            $display("%0t: digit beat %s: expected seg=%02h sel=%h colon=%b last=%b",
                     $realtime, what, want.segment_bits, want.digit_select,
                     want.colon_on, want.last);
            $display("%0t:   actual seg=%02h sel=%h colon=%b last=%b",
                     $realtime, got.segment_bits, got.digit_select,
                     got.colon_on, got.last);
        end
        mismatches++;
    endtask

    // Predict on each accepted command, then compare the beat of this cycle.
    always @(posedge i_clk) begin
        t_digit_beat got;
        t_digit_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                shown_glyphs[i] = '0;
                lit_dots[i]     = 1'b0;
            end
            colon_lit = 1'b0;
            digit_beats_due.delete();
            mismatches = 0;
        end else begin
            if (i_start && (i_busy === 1'b0)) begin
                apply_command(i_func, i_hour, i_minute, i_second, i_temperature,
                              i_outdoor, i_position, i_glyph);
            end
            if (i_valid !== 1'b0) begin
                got = {i_segment_bits, i_digit_select, i_colon_on, i_last};
                if (digit_beats_due.size() == 0) begin
                    note_mismatch("with none due", '0, got);
                end else begin
                    want = digit_beats_due.pop_front();
                    if (got.segment_bits !== want.segment_bits
                            || got.digit_select !== want.digit_select
                            || got.colon_on !== want.colon_on
                            || got.last !== want.last) begin
                        note_mismatch("differs", want, got);
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_beats_pending  <= digit_beats_due.size();
    end

endmodule

// ----- tb/tb_seven_segment_four_digit_formatter_core.sv -----
`timescale 1ns / 1ps

module tb_seven_segment_four_digit_formatter_core;
    import ssfmt_pkg::*;

    localparam int NUM_DIGITS   = 4;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = NUM_DIGITS + 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic [1:0] i_func;
    logic [4:0] i_hour;
    logic [5:0] i_minute;
    logic [5:0] i_second;
    logic [7:0] i_temperature;
    logic       i_outdoor;
    logic [1:0] i_position;
    logic [3:0] i_glyph;
    logic       o_busy;
    logic       o_valid;
    logic [7:0] o_segment_bits;
    logic [3:0] o_digit_select;
    logic       o_colon_on;
    logic       o_last;

    int mismatch_count;
    int beats_pending;
    int cycle_count;

    seven_segment_four_digit_formatter_core #(
        .NUM_DIGITS(NUM_DIGITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_temperature (i_temperature),
        .i_outdoor     (i_outdoor),
        .i_position    (i_position),
        .i_glyph       (i_glyph),
        .o_valid       (o_valid),
        .o_segment_bits(o_segment_bits),
        .o_digit_select(o_digit_select),
        .o_colon_on    (o_colon_on),
        .o_last        (o_last)
    );

    ssfmt_beat_checker #(
        .NUM_DIGITS(NUM_DIGITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_func          (i_func),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second        (i_second),
        .i_temperature   (i_temperature),
        .i_outdoor       (i_outdoor),
        .i_position      (i_position),
        .i_glyph         (i_glyph),
        .i_valid         (o_valid),
        .i_segment_bits  (o_segment_bits),
        .i_digit_select  (o_digit_select),
        .i_colon_on      (o_colon_on),
        .i_last          (o_last),
        .o_mismatch_count(mismatch_count),
        .o_beats_pending (beats_pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[seven_segment_four_digit_formatter_core] ERROR");
            $finish;
        end
    end

    // Present one command and hold it until the block takes the command.
    task automatic issue_command(input logic [1:0] func, input logic [4:0] hour,
                                 input logic [5:0] minute, input logic [5:0] second,
                                 input logic [7:0] temperature, input logic outdoor,
                                 input logic [1:0] position, input logic [3:0] glyph);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_func        <= func;
        i_hour        <= hour;
        i_minute      <= minute;
        i_second      <= second;
        i_temperature <= temperature;
        i_outdoor     <= outdoor;
        i_position    <= position;
        i_glyph       <= glyph;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and scramble the idle command fields.
    task automatic idle_cycles(input int count);
        repeat (count) begin
            @(negedge i_clk);
            i_start       <= 1'b0;
            i_func        <= 2'($urandom);
            i_hour        <= 5'($urandom);
            i_minute      <= 6'($urandom);
            i_second      <= 6'($urandom);
            i_temperature <= 8'($urandom);
            i_outdoor     <= 1'($urandom);
            i_position    <= 2'($urandom);
            i_glyph       <= 4'($urandom);
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_random_command();
        logic [1:0] func;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] temperature;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 25)      func = FUNC_TIME;
        else if (r < 50) func = FUNC_TEMP;
        else if (r < 70) func = FUNC_GLYPH;
        else             func = FUNC_SCAN;
        // Keep most clock values legal, let some run past range
        hour   = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 23)) : 5'($urandom);
        minute = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 59)) : 6'($urandom);
        // Bias temperature toward the display limits now and then
        if ($urandom_range(0, 99) < 85) begin
            temperature = 8'($urandom);
        end else begin
            case ($urandom_range(0, 7))
                0: temperature = 8'h80;
                1: temperature = 8'h7F;
                2: temperature = 8'd99;
                3: temperature = 8'd100;
                4: temperature = 8'h9D;
                5: temperature = 8'h9C;
                6: temperature = 8'h00;
                default: temperature = 8'hFF;
            endcase
        end
        issue_command(func, hour, minute, 6'($urandom), temperature, 1'($urandom),
                      2'($urandom), 4'($urandom));
    endtask

    initial begin
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_func        = '0;
        i_hour        = '0;
        i_minute      = '0;
        i_second      = '0;
        i_temperature = '0;
        i_outdoor     = 1'b0;
        i_position    = '0;
        i_glyph       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset image, clock extremes, temperature limits, glyph writes
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TIME,  5'd23, 6'd59, 6'd59, 8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TIME,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TIME,  5'd31, 6'd63, 6'd1,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TEMP,  5'd0,  6'd0,  6'd0,  8'h80, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TEMP,  5'd0,  6'd0,  6'd0,  8'h7F, 1'b1, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TEMP,  5'd0,  6'd0,  6'd0,  8'd99, 1'b1, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TEMP,  5'd0,  6'd0,  6'd0,  8'h9D, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_TEMP,  5'd0,  6'd0,  6'd0,  8'h9C, 1'b1, 2'd0, 4'd0);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_GLYPH, 5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd15);
        issue_command(FUNC_GLYPH, 5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd1, GL_O);
        issue_command(FUNC_GLYPH, 5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd2, GL_N);
        issue_command(FUNC_GLYPH, 5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd3, GL_DEGREE);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);
        issue_command(FUNC_GLYPH, 5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd3, GL_C);
        issue_command(FUNC_SCAN,  5'd0,  6'd0,  6'd0,  8'h00, 1'b0, 2'd0, 4'd0);

        // Random commands with random gaps between them
        repeat (RANDOM_ITEMS) begin
            idle_cycles(pick_gap());
            issue_random_command();
        end
        idle_cycles(1);

        // Drain outstanding beats, then watch for stray ones
        do @(negedge i_clk); while (beats_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("[seven_segment_four_digit_formatter_core] OK");
        end else begin
            $display("[seven_segment_four_digit_formatter_core] ERROR");
        end
        $finish;
    end

endmodule
